@@ rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CMD_W        = 3;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_RETRIEVE = 3'd2,
        CMD_LOCATE   = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_POS   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_DEL_SHIFT,
        ST_DEL_DRAIN,
        ST_READ,
        ST_SCAN
    } state_t;

endpackage

@@ rtl/positional_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values held in one synchronous memory.
// Clear, rejected and unused commands, locate on an empty list, insert at the
// end and delete of the last entry finish straight from idle; retrieve does
// one memory read; other inserts shift entries up from the end down to the
// position, then write the value; other deletes shift the later entries down;
// locate scans from entry 0 until a match or the last entry. One command at a
// time; each memory move uses the single write port. The done strobe cannot be stalled.
// Reset clears the count and the control state; entries are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [CNT_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0] read_value,
    output logic [IDX_W-1:0]        found_position,
    output logic [CNT_W-1:0]        item_count
);

    logic [VAL_W-1:0] mem [CAPACITY];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             scan_end_reg, scan_end_next;
    logic [CNT_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic             rv_reg;
    logic [IDX_W-1:0] raddr_d_reg;
    logic [VAL_W-1:0] rdat_reg;

    logic             done_reg;
    status_t          status_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic [IDX_W-1:0] found_reg;

    logic             accept;
    logic             re, we;
    logic [IDX_W-1:0] ra, wa;
    logic [VAL_W-1:0] wd;
    logic             fin;
    status_t          fin_status;
    logic [VAL_W-1:0] fin_rd;
    logic [IDX_W-1:0] fin_fpos;

    logic [CNT_W-1:0] cnt_last;
    logic             pos_gt_cnt, pos_ge_cnt, pos_eq_cnt, pos_eq_last;
    logic             cnt_full, cnt_zero;
    logic             ptr_at_pos, ptr_at_last, hit, rd_at_last;

    assign accept      = start && (state_reg == ST_IDLE);
    assign cnt_last    = count_reg - 1'b1;
    assign pos_gt_cnt  = position > count_reg;
    assign pos_ge_cnt  = position >= count_reg;
    assign pos_eq_cnt  = position == count_reg;
    assign pos_eq_last = position == cnt_last;
    assign cnt_full    = count_reg == CNT_W'(CAPACITY);
    assign cnt_zero    = count_reg == '0;
    assign ptr_at_pos  = CNT_W'(ptr_reg) == pos_reg;
    assign ptr_at_last = CNT_W'(ptr_reg) == cnt_last;
    assign hit         = rv_reg && (rdat_reg == val_reg);
    assign rd_at_last  = CNT_W'(raddr_d_reg) == cnt_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority case (cmd_t'(cmd))
                        CMD_INSERT:
                            if (!pos_gt_cnt && !cnt_full && !pos_eq_cnt)
                                state_next = ST_INS_SHIFT;
                        CMD_DELETE:
                            if (!pos_ge_cnt && !pos_eq_last)
                                state_next = ST_DEL_SHIFT;
                        CMD_RETRIEVE:
                            if (!pos_ge_cnt)
                                state_next = ST_READ;
                        CMD_LOCATE:
                            if (!cnt_zero)
                                state_next = ST_SCAN;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_SHIFT:
                if (ptr_at_pos)
                    state_next = ST_INS_PUT;
            ST_INS_PUT:
                if (!rv_reg)
                    state_next = ST_IDLE;
            ST_DEL_SHIFT:
                if (ptr_at_last)
                    state_next = ST_DEL_DRAIN;
            ST_DEL_DRAIN:
                state_next = ST_IDLE;
            ST_READ:
                state_next = ST_IDLE;
            ST_SCAN:
                if (hit || (rv_reg && rd_at_last))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        scan_end_next = scan_end_reg;
        re            = 1'b0;
        ra            = ptr_reg;
        we            = 1'b0;
        wa            = raddr_d_reg + 1'b1;
        wd            = rdat_reg;
        fin           = 1'b0;
        fin_status    = STAT_OK;
        fin_rd        = '0;
        fin_fpos      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority case (cmd_t'(cmd))
                        CMD_INSERT:
                        begin
                            if (pos_gt_cnt)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_BAD_POS;
                            end
                            else if (cnt_full)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_FULL;
                            end
                            else if (pos_eq_cnt)
                            begin
                                we         = 1'b1;
                                wa         = position[IDX_W-1:0];
                                wd         = value;
                                count_next = count_reg + 1'b1;
                                fin        = 1'b1;
                            end
                            else
                                ptr_next = cnt_last[IDX_W-1:0];
                        end
                        CMD_DELETE:
                        begin
                            if (pos_ge_cnt)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_BAD_POS;
                            end
                            else if (pos_eq_last)
                            begin
                                count_next = cnt_last;
                                fin        = 1'b1;
                            end
                            else
                                ptr_next = position[IDX_W-1:0] + 1'b1;
                        end
                        CMD_RETRIEVE:
                        begin
                            if (pos_ge_cnt)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_BAD_POS;
                            end
                            else
                            begin
                                re = 1'b1;
                                ra = position[IDX_W-1:0];
                            end
                        end
                        CMD_LOCATE:
                        begin
                            if (cnt_zero)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                ptr_next      = '0;
                                scan_end_next = 1'b0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        default:
                            fin = 1'b1;
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                re = 1'b1;
                we = rv_reg;
                if (!ptr_at_pos)
                    ptr_next = ptr_reg - 1'b1;
            end
            ST_INS_PUT:
            begin
                we = 1'b1;
                if (!rv_reg)
                begin
                    wa         = pos_reg[IDX_W-1:0];
                    wd         = val_reg;
                    count_next = count_reg + 1'b1;
                    fin        = 1'b1;
                end
            end
            ST_DEL_SHIFT:
            begin
                re = 1'b1;
                we = rv_reg;
                wa = raddr_d_reg - 1'b1;
                if (!ptr_at_last)
                    ptr_next = ptr_reg + 1'b1;
            end
            ST_DEL_DRAIN:
            begin
                we         = 1'b1;
                wa         = raddr_d_reg - 1'b1;
                count_next = cnt_last;
                fin        = 1'b1;
            end
            ST_READ:
            begin
                fin    = 1'b1;
                fin_rd = rdat_reg;
            end
            ST_SCAN:
            begin
                re = !scan_end_reg;
                if (!scan_end_reg)
                begin
                    if (ptr_at_last)
                        scan_end_next = 1'b1;
                    else
                        ptr_next = ptr_reg + 1'b1;
                end
                if (hit)
                begin
                    fin      = 1'b1;
                    fin_fpos = raddr_d_reg;
                end
                else if (rv_reg && rd_at_last)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
        begin
            rdat_reg    <= mem[ra];
            raddr_d_reg <= ra;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= position;
            val_reg <= value;
        end
        if (fin)
        begin
            status_reg     <= fin_status;
            read_value_reg <= fin_rd;
            found_reg      <= fin_fpos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            scan_end_reg <= 1'b0;
            rv_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            scan_end_reg <= scan_end_next;
            rv_reg       <= re;
            done_reg     <= fin;
        end
    end

    assign busy           = state_reg != ST_IDLE;
    assign done           = done_reg;
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_reg;
    assign item_count     = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("done strobe while a command is in progress");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (wa != ra))
        else $error("read and write to the same entry in one cycle");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_PUT && !rv_reg) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance the count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEL_DRAIN) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not drop the count");

endmodule

@@ sim/tb_positional_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_core
// Self-checking bench for the positional list engine. A short table of corner
// cases runs first: empty list, bad positions, extreme values, unused codes
// and clear. Random command streams follow that fill, drain and query the
// list under several sender idle rates. Each done transfer is scored field by
// field, against the table's fixed result or else a behavioral list model.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_core;
    import ple_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int LIST_CAP        = CAPACITY_DEF;
    localparam int POS_W           = $clog2(LIST_CAP + 1);
    localparam int IDX_W           = $clog2(LIST_CAP);
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 2 * LIST_CAP + 8;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int BURST_LEN       = 24;
    localparam int NUM_ROWS        = 22;
    localparam int NUM_PHASES      = 4;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_ONES = 32'shFFFF_FFFF;

    typedef enum int {
        STREAM_FILL,
        STREAM_DRAIN,
        STREAM_MIXED,
        STREAM_QUERY
    } stream_mode_t;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] read_value;
        logic [IDX_W-1:0]        found_position;
        logic [POS_W-1:0]        item_count;
    } list_result_t;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        bit                      fixed;
        list_result_t            want;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        cmd = '0;
    logic [POS_W-1:0]        position = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    done;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [IDX_W-1:0]        found_position;
    logic [POS_W-1:0]        item_count;

    logic signed [VAL_W-1:0] model_entries [LIST_CAP];
    int                      model_count;
    list_result_t            pending_results [$];
    stim_row_t               directed_rows [NUM_ROWS];

    bit                      use_fixed = 1'b0;
    list_result_t            fixed_result;
    int                      idle_pct = 0;
    int                      error_count = 0;
    int                      cycle_count = 0;

    positional_list_engine_core #(
        .CAPACITY(LIST_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .position(position),
        .value(value),
        .done(done),
        .status(status),
        .read_value(read_value),
        .found_position(found_position),
        .item_count(item_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] c,
            logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
        list_result_t r;
        int           i;
        bit           hit;
        r.status         = STAT_OK;
        r.read_value     = '0;
        r.found_position = '0;
        hit              = 1'b0;
        case (c)
            CMD_INSERT:
            begin
                if (int'(p) > model_count)
                    r.status = STAT_BAD_POS;
                else if (model_count >= LIST_CAP)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = model_count; i > int'(p); i--)
                        model_entries[i] = model_entries[i - 1];
                    model_entries[p] = v;
                    model_count++;
                end
            end
            CMD_DELETE:
            begin
                if (int'(p) >= model_count)
                    r.status = STAT_BAD_POS;
                else
                begin
                    for (i = int'(p); i + 1 < model_count; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_count--;
                end
            end
            CMD_RETRIEVE:
            begin
                if (int'(p) >= model_count)
                    r.status = STAT_BAD_POS;
                else
                    r.read_value = model_entries[p];
            end
            CMD_LOCATE:
            begin
                r.status = STAT_NOT_FOUND;
                for (i = 0; i < model_count; i++)
                begin
                    if (!hit && model_entries[i] == v)
                    begin
                        hit              = 1'b1;
                        r.status         = STAT_OK;
                        r.found_position = IDX_W'(i);
                    end
                end
            end
            CMD_CLEAR:
                model_count = 0;
            default:
                ;
        endcase
        r.item_count = POS_W'(model_count);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(bit for_insert);
        if ($urandom_range(99) < 20)
            return POS_W'($urandom_range((1 << POS_W) - 1));
        if (for_insert)
            return POS_W'($urandom_range(model_count));
        if (model_count == 0)
            return '0;
        return POS_W'($urandom_range(model_count - 1));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 35 && model_count > 0)
            return model_entries[$urandom_range(model_count - 1)];
        if (r < 50)
        begin
            case ($urandom_range(4))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                3:       return VAL_ONES;
                default: return 32'sd1;
            endcase
        end
        return VAL_W'($urandom);
    endfunction

    task automatic send_cmd(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
            logic signed [VAL_W-1:0] v, bit fixed, list_result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start        <= 1'b1;
        cmd          <= c;
        position     <= p;
        value        <= v;
        use_fixed    = fixed;
        fixed_result = want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic run_random(int count);
        int               k;
        int               r;
        stream_mode_t     mode;
        logic [CMD_W-1:0] c;
        list_result_t     none;
        none = '{STAT_OK, 32'sd0, 4'd0, 5'd0};
        mode = STREAM_MIXED;
        for (k = 0; k < count; k++)
        begin
            if (k % BURST_LEN == 0)
                mode = stream_mode_t'($urandom_range(3));
            r = $urandom_range(99);
            case (mode)
                STREAM_FILL:
                    c = (r < 70) ? CMD_INSERT : (r < 80) ? CMD_RETRIEVE :
                        (r < 92) ? CMD_LOCATE : CMD_W'($urandom_range(7));
                STREAM_DRAIN:
                    c = (r < 60) ? CMD_DELETE : (r < 75) ? CMD_RETRIEVE :
                        (r < 88) ? CMD_LOCATE : (r < 91) ? CMD_CLEAR :
                        CMD_W'($urandom_range(7));
                STREAM_QUERY:
                    c = (r < 45) ? CMD_RETRIEVE : (r < 90) ? CMD_LOCATE : CMD_INSERT;
                default:
                begin
                    c = CMD_W'($urandom_range(7));
                    if (c == CMD_CLEAR && $urandom_range(3) != 0)
                        c = CMD_LOCATE;
                end
            endcase
            send_cmd(c, pick_position(c == CMD_INSERT), pick_value(), 1'b0, none);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transfer: status %0d count %0d",
                           status, item_count);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        error_count++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, read_value);
                        error_count++;
                    end
                    if (found_position !== want.found_position)
                    begin
                        $error("found_position: expected %0d, actual %0d",
                               want.found_position, found_position);
                        error_count++;
                    end
                    if (item_count !== want.item_count)
                    begin
                        $error("item_count: expected %0d, actual %0d",
                               want.item_count, item_count);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                pred = apply_list_cmd(cmd, position, value);
                pending_results.push_back(use_fixed ? fixed_result : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int i;
        int ph;
        int phase_idle [NUM_PHASES];
        phase_idle = '{0, 88, 0, 27};
        model_count = 0;
        for (i = 0; i < LIST_CAP; i++)
            model_entries[i] = '0;
        fixed_result = '{STAT_OK, 32'sd0, 4'd0, 5'd0};

        directed_rows[0]  = '{CMD_RETRIEVE, 5'd0, 32'sd0, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd0}};
        directed_rows[1]  = '{CMD_DELETE, 5'd0, 32'sd0, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd0}};
        directed_rows[2]  = '{CMD_LOCATE, 5'd0, 32'sd0, 1'b1,
                              '{STAT_NOT_FOUND, 32'sd0, 4'd0, 5'd0}};
        directed_rows[3]  = '{CMD_INSERT, 5'd1, 32'sd5, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd0}};
        directed_rows[4]  = '{CMD_INSERT, 5'd0, VAL_MAX, 1'b1,
                              '{STAT_OK, 32'sd0, 4'd0, 5'd1}};
        directed_rows[5]  = '{CMD_INSERT, 5'd1, VAL_MIN, 1'b1,
                              '{STAT_OK, 32'sd0, 4'd0, 5'd2}};
        directed_rows[6]  = '{CMD_INSERT, 5'd0, VAL_ONES, 1'b0, fixed_result};
        directed_rows[7]  = '{CMD_RETRIEVE, 5'd2, 32'sd0, 1'b0, fixed_result};
        directed_rows[8]  = '{CMD_RETRIEVE, 5'd3, 32'sd0, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd3}};
        directed_rows[9]  = '{CMD_LOCATE, 5'd0, VAL_MAX, 1'b0, fixed_result};
        directed_rows[10] = '{CMD_LOCATE, 5'd0, 32'sd12345, 1'b1,
                              '{STAT_NOT_FOUND, 32'sd0, 4'd0, 5'd3}};
        directed_rows[11] = '{CMD_INSERT, 5'd4, 32'sd7, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd3}};
        directed_rows[12] = '{CMD_DELETE, 5'd3, 32'sd0, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd3}};
        directed_rows[13] = '{CMD_DELETE, 5'd31, 32'sd0, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd3}};
        directed_rows[14] = '{CMD_INSERT, 5'd16, VAL_MIN, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd3}};
        directed_rows[15] = '{CMD_DELETE, 5'd0, 32'sd0, 1'b0, fixed_result};
        directed_rows[16] = '{CMD_SPARE_LO, 5'd0, 32'sd0, 1'b1,
                              '{STAT_OK, 32'sd0, 4'd0, 5'd2}};
        directed_rows[17] = '{CMD_SPARE_HI, 5'd31, VAL_ONES, 1'b1,
                              '{STAT_OK, 32'sd0, 4'd0, 5'd2}};
        directed_rows[18] = '{CMD_RETRIEVE, 5'd0, 32'sd0, 1'b0, fixed_result};
        directed_rows[19] = '{CMD_CLEAR, 5'd0, 32'sd0, 1'b1,
                              '{STAT_OK, 32'sd0, 4'd0, 5'd0}};
        directed_rows[20] = '{CMD_RETRIEVE, 5'd0, 32'sd0, 1'b1,
                              '{STAT_BAD_POS, 32'sd0, 4'd0, 5'd0}};
        directed_rows[21] = '{CMD_INSERT, 5'd0, 32'sd0, 1'b1,
                              '{STAT_OK, 32'sd0, 4'd0, 5'd1}};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 0;
        for (i = 0; i < NUM_ROWS; i++)
            send_cmd(directed_rows[i].cmd, directed_rows[i].position,
                     directed_rows[i].value, directed_rows[i].fixed,
                     directed_rows[i].want);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_pct = phase_idle[ph];
            run_random(ITEMS_PER_PHASE);
            @(negedge clk);
            start <= 1'b0;
            // hold off until every transfer is back
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ple_pkg.sv
rtl/positional_list_engine_core.sv
sim/tb_positional_list_engine_core.sv
